### rtl/cbd_pkg.sv
// Shared types, constants and probability tables of the CABAC bin decoder.
// No dependencies; cbd_front, cbd_back and the top level import this package.
package cbd_pkg;

  localparam int CTX_COUNT = 1024;
  localparam int CTX_AW    = $clog2(CTX_COUNT);
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [8:0] RANGE_START = 9'd510;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_CTX    = 2'd2,
    CMD_BYPASS = 2'd3
  } cbd_cmd_t;

  typedef struct packed {
    cbd_cmd_t    cmd;
    logic [9:0]  ctx_index;
    logic [7:0]  ctx_value;
    logic [8:0]  stream_bits;
    logic        in_store;
  } cbd_item_t;

  localparam logic [7:0] LPS_TAB [256] = '{
    8'd128, 8'd176, 8'd208, 8'd240, 8'd128, 8'd167, 8'd197, 8'd227,
    8'd128, 8'd158, 8'd187, 8'd216, 8'd123, 8'd150, 8'd178, 8'd205,
    8'd116, 8'd142, 8'd169, 8'd195, 8'd111, 8'd135, 8'd160, 8'd185,
    8'd105, 8'd128, 8'd152, 8'd175, 8'd100, 8'd122, 8'd144, 8'd166,
    8'd95,  8'd116, 8'd137, 8'd158, 8'd90,  8'd110, 8'd130, 8'd150,
    8'd85,  8'd104, 8'd123, 8'd142, 8'd81,  8'd99,  8'd117, 8'd135,
    8'd77,  8'd94,  8'd111, 8'd128, 8'd73,  8'd89,  8'd105, 8'd122,
    8'd69,  8'd85,  8'd100, 8'd116, 8'd66,  8'd80,  8'd95,  8'd110,
    8'd62,  8'd76,  8'd90,  8'd104, 8'd59,  8'd72,  8'd86,  8'd99,
    8'd56,  8'd69,  8'd81,  8'd94,  8'd53,  8'd65,  8'd77,  8'd89,
    8'd51,  8'd62,  8'd73,  8'd85,  8'd48,  8'd59,  8'd69,  8'd80,
    8'd46,  8'd56,  8'd66,  8'd76,  8'd43,  8'd53,  8'd63,  8'd72,
    8'd41,  8'd50,  8'd59,  8'd69,  8'd39,  8'd48,  8'd56,  8'd65,
    8'd37,  8'd45,  8'd54,  8'd62,  8'd35,  8'd43,  8'd51,  8'd59,
    8'd33,  8'd41,  8'd48,  8'd56,  8'd32,  8'd39,  8'd46,  8'd53,
    8'd30,  8'd37,  8'd43,  8'd50,  8'd29,  8'd35,  8'd41,  8'd48,
    8'd27,  8'd33,  8'd39,  8'd45,  8'd26,  8'd31,  8'd37,  8'd43,
    8'd24,  8'd30,  8'd35,  8'd41,  8'd23,  8'd28,  8'd33,  8'd39,
    8'd22,  8'd27,  8'd32,  8'd37,  8'd21,  8'd26,  8'd30,  8'd35,
    8'd20,  8'd24,  8'd29,  8'd33,  8'd19,  8'd23,  8'd27,  8'd31,
    8'd18,  8'd22,  8'd26,  8'd30,  8'd17,  8'd21,  8'd25,  8'd28,
    8'd16,  8'd20,  8'd23,  8'd27,  8'd15,  8'd19,  8'd22,  8'd25,
    8'd14,  8'd18,  8'd21,  8'd24,  8'd14,  8'd17,  8'd20,  8'd23,
    8'd13,  8'd16,  8'd19,  8'd22,  8'd12,  8'd15,  8'd18,  8'd21,
    8'd12,  8'd14,  8'd17,  8'd20,  8'd11,  8'd14,  8'd16,  8'd19,
    8'd11,  8'd13,  8'd15,  8'd18,  8'd10,  8'd12,  8'd15,  8'd17,
    8'd10,  8'd12,  8'd14,  8'd16,  8'd9,   8'd11,  8'd13,  8'd15,
    8'd9,   8'd11,  8'd12,  8'd14,  8'd8,   8'd10,  8'd12,  8'd14,
    8'd8,   8'd9,   8'd11,  8'd13,  8'd7,   8'd9,   8'd11,  8'd12,
    8'd7,   8'd9,   8'd10,  8'd12,  8'd7,   8'd8,   8'd10,  8'd11,
    8'd6,   8'd8,   8'd9,   8'd11,  8'd6,   8'd7,   8'd9,   8'd10,
    8'd6,   8'd7,   8'd8,   8'd9,   8'd2,   8'd2,   8'd2,   8'd2
  };

  localparam logic [7:0] NEXT_TAB [256] = '{
    8'd4,   8'd5,   8'd253, 8'd252, 8'd8,   8'd9,   8'd153, 8'd152,
    8'd12,  8'd13,  8'd153, 8'd152, 8'd16,  8'd17,  8'd149, 8'd148,
    8'd20,  8'd21,  8'd149, 8'd148, 8'd24,  8'd25,  8'd149, 8'd148,
    8'd28,  8'd29,  8'd145, 8'd144, 8'd32,  8'd33,  8'd145, 8'd144,
    8'd36,  8'd37,  8'd145, 8'd144, 8'd40,  8'd41,  8'd141, 8'd140,
    8'd44,  8'd45,  8'd141, 8'd140, 8'd48,  8'd49,  8'd141, 8'd140,
    8'd52,  8'd53,  8'd137, 8'd136, 8'd56,  8'd57,  8'd137, 8'd136,
    8'd60,  8'd61,  8'd133, 8'd132, 8'd64,  8'd65,  8'd133, 8'd132,
    8'd68,  8'd69,  8'd133, 8'd132, 8'd72,  8'd73,  8'd129, 8'd128,
    8'd76,  8'd77,  8'd129, 8'd128, 8'd80,  8'd81,  8'd125, 8'd124,
    8'd84,  8'd85,  8'd121, 8'd120, 8'd88,  8'd89,  8'd121, 8'd120,
    8'd92,  8'd93,  8'd121, 8'd120, 8'd96,  8'd97,  8'd117, 8'd116,
    8'd100, 8'd101, 8'd117, 8'd116, 8'd104, 8'd105, 8'd113, 8'd112,
    8'd108, 8'd109, 8'd109, 8'd108, 8'd112, 8'd113, 8'd109, 8'd108,
    8'd116, 8'd117, 8'd105, 8'd104, 8'd120, 8'd121, 8'd105, 8'd104,
    8'd124, 8'd125, 8'd101, 8'd100, 8'd128, 8'd129, 8'd97,  8'd96,
    8'd132, 8'd133, 8'd97,  8'd96,  8'd136, 8'd137, 8'd93,  8'd92,
    8'd140, 8'd141, 8'd89,  8'd88,  8'd144, 8'd145, 8'd89,  8'd88,
    8'd148, 8'd149, 8'd85,  8'd84,  8'd152, 8'd153, 8'd85,  8'd84,
    8'd156, 8'd157, 8'd77,  8'd76,  8'd160, 8'd161, 8'd77,  8'd76,
    8'd164, 8'd165, 8'd73,  8'd72,  8'd168, 8'd169, 8'd73,  8'd72,
    8'd172, 8'd173, 8'd65,  8'd64,  8'd176, 8'd177, 8'd65,  8'd64,
    8'd180, 8'd181, 8'd61,  8'd60,  8'd184, 8'd185, 8'd61,  8'd60,
    8'd188, 8'd189, 8'd53,  8'd52,  8'd192, 8'd193, 8'd53,  8'd52,
    8'd196, 8'd197, 8'd49,  8'd48,  8'd200, 8'd201, 8'd45,  8'd44,
    8'd204, 8'd205, 8'd45,  8'd44,  8'd208, 8'd209, 8'd37,  8'd36,
    8'd212, 8'd213, 8'd37,  8'd36,  8'd216, 8'd217, 8'd33,  8'd32,
    8'd220, 8'd221, 8'd29,  8'd28,  8'd224, 8'd225, 8'd25,  8'd24,
    8'd228, 8'd229, 8'd21,  8'd20,  8'd232, 8'd233, 8'd17,  8'd16,
    8'd236, 8'd237, 8'd17,  8'd16,  8'd240, 8'd241, 8'd9,   8'd8,
    8'd244, 8'd245, 8'd9,   8'd8,   8'd248, 8'd249, 8'd5,   8'd4,
    8'd248, 8'd249, 8'd1,   8'd0,   8'd252, 8'd253, 8'd0,   8'd1
  };

endpackage

### rtl/cbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; a read of the address being written returns the old data.
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cbd_front.sv
// Front end of the CABAC bin decoder: accepts command beats, classifies them
// and holds them in a short queue for the back end. Depends on cbd_pkg.
module cbd_front import cbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  // command[1:0], ctx_index[11:2], ctx_value[19:12], stream_bits[28:20], zero pad
  input  logic [31:0] s_tdata,
  output cbd_item_t head,
  output logic      head_valid,
  input  logic      pop
);

  cbd_item_t       slots [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    count;
  logic [QAW:0]    count_next;
  logic            push;
  cbd_item_t       item;

  always_comb begin
    item.cmd         = cbd_cmd_t'(s_tdata[1:0]);
    item.ctx_index   = s_tdata[11:2];
    item.ctx_value   = s_tdata[19:12];
    item.stream_bits = s_tdata[28:20];
    item.in_store    = {1'b0, s_tdata[11:2]} < 11'(CTX_COUNT);
  end

  assign s_tready   = count != (QAW+1)'(QDEPTH);
  assign push       = s_tvalid && s_tready;
  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("Queue popped while empty.");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("Queue count exceeds its depth.");

endmodule

### rtl/cbd_back.sv
// Back end of the CABAC bin decoder: context RAM read stage, arithmetic
// update of range and offset, and the result register. Depends on cbd_pkg, cbd_ram.
module cbd_back import cbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cbd_item_t head,
  input  logic      head_valid,
  output logic      pop,
  output logic      m_tvalid,
  input  logic      m_tready,
  // bin_value[0], bits_used[4:1], zero pad
  output logic [7:0] m_tdata
);

  cbd_item_t   rd_item;
  logic        rd_valid;
  logic        fwd_valid;
  logic [7:0]  fwd_data;
  logic [7:0]  ram_rdata;
  logic        exec_fire;
  logic        we;
  logic [7:0]  wdata;

  logic [8:0]  arith_range;
  logic [8:0]  arith_offset;
  logic [8:0]  range_next;
  logic [8:0]  offset_next;
  logic        out_bin;
  logic [3:0]  out_used;
  logic        bin_next;
  logic [3:0]  used_next;

  logic [7:0]  ctx;
  logic [7:0]  lps;
  logic [8:0]  mps_range;
  logic        lps_path;
  logic [7:0]  look;
  logic [8:0]  range_pre;
  logic [8:0]  offset_pre;
  logic [3:0]  shifts;
  logic [17:0] shifted;
  logic [9:0]  wide;
  logic        byp_hit;

  assign exec_fire = rd_valid && (!m_tvalid || m_tready);
  assign pop       = head_valid && (!rd_valid || exec_fire);
  assign we        = exec_fire && rd_item.in_store &&
                     (rd_item.cmd == CMD_WRITE || rd_item.cmd == CMD_CTX);

  cbd_ram #(.WIDTH(8), .DEPTH(CTX_COUNT)) u_ctx_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rd_item.ctx_index[CTX_AW-1:0]),
    .wdata (wdata),
    .re    (pop),
    .raddr (head.ctx_index[CTX_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ctx = !rd_item.in_store ? 8'd0 : (fwd_valid ? fwd_data : ram_rdata);

  always_comb begin
    lps       = LPS_TAB[{ctx[7:2], arith_range[7:6]}];
    mps_range = arith_range - {1'b0, lps};
    lps_path  = arith_offset >= mps_range;
    look      = lps_path ? ~ctx : ctx;
    range_pre = lps_path ? {1'b0, lps} : mps_range;
    offset_pre = lps_path ? arith_offset - mps_range : arith_offset;
    shifts = 4'd9;
    for (int i = 0; i < 9; i++) begin
      if (range_pre[i]) begin
        shifts = 4'(8 - i);
      end
    end
    shifted = {offset_pre, rd_item.stream_bits} << shifts;
    wide    = {arith_offset, rd_item.stream_bits[8]};
    byp_hit = wide >= {1'b0, arith_range};
  end

  always_comb begin
    range_next  = arith_range;
    offset_next = arith_offset;
    bin_next    = 1'b0;
    used_next   = 4'd0;
    wdata       = rd_item.ctx_value;
    unique case (rd_item.cmd)
      CMD_WRITE: begin
        wdata = rd_item.ctx_value;
      end
      CMD_START: begin
        range_next  = RANGE_START;
        offset_next = rd_item.stream_bits;
        used_next   = 4'd9;
      end
      CMD_CTX: begin
        range_next  = range_pre << shifts;
        offset_next = shifted[17:9];
        bin_next    = look[0];
        used_next   = shifts;
        wdata       = NEXT_TAB[look];
      end
      CMD_BYPASS: begin
        offset_next = byp_hit ? 9'(wide - {1'b0, arith_range}) : wide[8:0];
        bin_next    = byp_hit;
        used_next   = 4'd1;
      end
      default: begin
        wdata = rd_item.ctx_value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      arith_range  <= RANGE_START;
      arith_offset <= '0;
    end else begin
      rd_valid <= pop || (rd_valid && !exec_fire);
      if (exec_fire) begin
        m_tvalid     <= 1'b1;
        arith_range  <= range_next;
        arith_offset <= offset_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_item   <= head;
      fwd_valid <= we && (rd_item.ctx_index[CTX_AW-1:0] == head.ctx_index[CTX_AW-1:0]);
      fwd_data  <= wdata;
    end
    if (exec_fire) begin
      out_bin  <= bin_next;
      out_used <= used_next;
    end
  end

  assign m_tdata = {3'b000, out_used, out_bin};

  a_range_norm: assert property (@(posedge clk) disable iff (rst) arith_range[8])
    else $error("Range left unnormalized.");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !exec_fire)
    else $error("Result overwritten while stalled.");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_used <= 4'd9)
    else $error("Bit count beyond nine.");

endmodule

### rtl/cabac_bin_decoder.sv
// Top level of the CABAC binary arithmetic bin decoder.
// Depends on cbd_pkg, cbd_front, cbd_back and cbd_ram.
//
// One command is accepted per cycle while s_tready is high, and one result
// beat is produced per command, in order. A command goes from the input beat
// into a four-entry queue, then into a stage that reads the 1024-entry
// context RAM, then through the combinational range and offset update into
// the result register, which raises m_tvalid. Sustained rate is one command
// per cycle while m_tready is held high; a context written by one command is
// forwarded to the command right behind it when that one reads the same
// entry. The context RAM is not cleared at reset: every entry must be
// written before a decode reads it. The caller advances its stream position
// by bits_used before presenting the next command's stream bits.
module cabac_bin_decoder import cbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], ctx_index[11:2], ctx_value[19:12], stream_bits[28:20], zero pad
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bin_value[0], bits_used[4:1], zero pad
  output logic [7:0]  m_tdata
);

  cbd_item_t head;
  logic      head_valid;
  logic      pop;

  cbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  cbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
